/* hw/rtl/assert_macros.svh */
// Assertion helper macros for the crossover block.
// Used by the top level only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hw/rtl/dmac_pkg.sv */
// Package for the moving average crossover block: constants and codes.
// No dependencies.
package dmac_pkg;
    localparam int MAX_WINDOW_DEF      = 64;
    localparam int NUM_INSTRUMENTS_DEF = 16;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_BUY  = 2'd1;
    localparam logic [1:0] ACT_SELL = 2'd2;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_WINDOW = 2'd1;
    localparam logic [1:0] REG_SHORT  = 2'd2;
    localparam logic [1:0] REG_LONG   = 2'd3;

    localparam logic [33:0] PRICE_OFFSET = 34'd768;
    localparam logic [6:0]  QTY_CAP      = 7'd100;
endpackage

/* hw/rtl/dual_moving_average_crossover.sv */
// Dual moving average crossover: one closing price in, one order decision out per
// transaction. A bar of an enabled instrument with a full window and valid lengths
// gets its result after one history memory read per cycle while the four sums
// accumulate, then four compare steps; a buy then also waits for the bit-serial
// divider. A disabled instrument, a window not yet full or bad lengths give the
// result in the cycle after the input.
// Items are taken one at a time; the result waits in an output register and the next
// input transaction can come in the cycle after the result transaction.
// Depends on dmac_pkg, dmac_div and assert_macros.svh.
`include "assert_macros.svh"
module dual_moving_average_crossover #(
    parameter int MAX_WINDOW      = dmac_pkg::MAX_WINDOW_DEF,
    parameter int NUM_INSTRUMENTS = dmac_pkg::NUM_INSTRUMENTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // fields from bit 0: instrument[3:0], close_price[35:4], available_funds[75:36],
    // open_volume[95:76], closed_volume[115:96], zero fill [119:116]
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fields from bit 0: action[1:0], order_instrument[5:2], order_price[39:6],
    // order_quantity[60:40], zero fill [63:61]
    output logic [63:0]  m_axis_tdata
);
    localparam int SW = $clog2(MAX_WINDOW);
    localparam int IW = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
    localparam int FW = $clog2(MAX_WINDOW + 1);
    localparam int AW = $clog2(NUM_INSTRUMENTS * MAX_WINDOW);

    typedef enum logic [2:0] {S_IDLE, S_SUM, S_CMP, S_DIV, S_OUT} t_state;

    t_state        r_state;
    logic [15:0]   r_en;
    logic [6:0]    r_win, r_cap;
    logic [5:0]    r_short, r_long;
    logic [FW-1:0] r_fill [NUM_INSTRUMENTS];
    logic [SW-1:0] r_newest [NUM_INSTRUMENTS];
    logic [31:0]   r_mem [NUM_INSTRUMENTS * MAX_WINDOW];
    logic [31:0]   r_rd;

    logic [3:0]    r_inst;
    logic [31:0]   r_close;
    logic [39:0]   r_funds;
    logic [19:0]   r_openv, r_closedv;
    logic [SW-1:0] r_slot;
    logic [6:0]    r_age;
    logic          r_rvalid;
    logic [6:0]    r_rage;
    logic [37:0]   r_s0, r_s1, r_l0, r_l1;
    logic [1:0]    r_cstep;
    logic [43:0]   r_a0, r_b0, r_a1, r_b1;
    logic          r_dstart;
    logic          r_mvalid;
    logic [63:0]   r_mdata;

    logic          w_acc, w_ok, w_store;
    logic [IW-1:0] w_idx, w_ridx;
    logic [SW-1:0] w_nslot, w_rslot;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [FW-1:0] w_nfill;
    logic [7:0]    w_inc;
    logic          w_div_done;
    logic [6:0]    w_qty;
    logic [6:0]    w_last;

    assign s_axis_tready = (r_state == S_IDLE) && !r_mvalid;
    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_idx   = IW'(s_axis_tdata[3:0]);
    assign w_ridx  = IW'(r_inst);
    assign w_store = (32'(s_axis_tdata[3:0]) < 32'(NUM_INSTRUMENTS))
                   && r_en[s_axis_tdata[3:0]];
    // ring slots wrap at MAX_WINDOW, the per-instrument memory depth
    assign w_nslot = (32'(r_newest[w_idx]) == 32'(MAX_WINDOW - 1)) ? '0
                   : r_newest[w_idx] + SW'(1);
    assign w_inc   = {1'b0, 7'(r_fill[w_idx])} + 8'd1;
    assign w_nfill = (w_inc < {1'b0, r_cap}) ? FW'(w_inc) : FW'(r_cap);
    assign w_ok    = (32'(w_nfill) >= 32'(r_win)) && (r_short != 0) && (r_long != 0)
                   && ({1'b0, r_short} < r_win) && ({1'b0, r_long} < r_win);
    assign w_rslot = (32'(r_slot) >= 32'(r_age)) ? SW'(32'(r_slot) - 32'(r_age))
                   : SW'(32'(r_slot) + 32'(MAX_WINDOW) - 32'(r_age));
    assign w_waddr = AW'(w_idx) * AW'(MAX_WINDOW) + AW'(w_nslot);
    assign w_raddr = AW'(w_ridx) * AW'(MAX_WINDOW) + AW'(w_rslot);
    assign w_last  = (r_short > r_long) ? {1'b0, r_short} : {1'b0, r_long};

    always_ff @(posedge i_clk) begin
        if (w_acc && w_store)
            r_mem[w_waddr] <= s_axis_tdata[35:4];
        r_rd <= r_mem[w_raddr];
    end

    dmac_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_funds(r_funds), .i_close(r_close), .o_done(w_div_done), .o_qty(w_qty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_en     <= 16'hFFFF;
            r_win    <= 7'd21;
            r_cap    <= 7'((MAX_WINDOW < 21) ? MAX_WINDOW : 21);
            r_short  <= 6'd5;
            r_long   <= 6'd20;
            r_mvalid <= 1'b0;
            r_rvalid <= 1'b0;
            r_dstart <= 1'b0;
            for (int i = 0; i < NUM_INSTRUMENTS; i++) begin
                r_fill[i]   <= '0;
                r_newest[i] <= '0;
            end
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_mvalid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dmac_pkg::REG_ENABLE: r_en <= i_cfg_data;
                    dmac_pkg::REG_WINDOW: begin
                        r_win <= i_cfg_data[6:0];
                        r_cap <= (32'(i_cfg_data[6:0]) < 32'(MAX_WINDOW)) ? i_cfg_data[6:0]
                                                                          : 7'(MAX_WINDOW);
                    end
                    dmac_pkg::REG_SHORT:  r_short <= i_cfg_data[5:0];
                    dmac_pkg::REG_LONG:   r_long <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: if (w_acc) begin
                    r_inst    <= s_axis_tdata[3:0];
                    r_close   <= s_axis_tdata[35:4];
                    r_funds   <= s_axis_tdata[75:36];
                    r_openv   <= s_axis_tdata[95:76];
                    r_closedv <= s_axis_tdata[115:96];
                    r_mdata   <= '0;
                    if (!w_store) begin
                        r_mvalid <= 1'b1;
                    end else begin
                        r_newest[w_idx] <= w_nslot;
                        r_fill[w_idx]   <= w_nfill;
                        r_slot <= w_nslot;
                        if (w_ok) begin
                            r_age <= '0;
                            r_s0 <= '0; r_s1 <= '0; r_l0 <= '0; r_l1 <= '0;
                            r_state <= S_SUM;
                        end else begin
                            r_mvalid <= 1'b1;
                        end
                    end
                end
                S_SUM: begin
                    // read age r_age now, data arrives next cycle
                    r_rvalid <= (r_age <= w_last);
                    r_rage   <= r_age;
                    r_age    <= r_age + 7'd1;
                    if (r_rvalid) begin
                        if (r_rage < {1'b0, r_short}) r_s0 <= r_s0 + 38'(r_rd);
                        if (r_rage >= 7'd1 && r_rage <= {1'b0, r_short})
                            r_s1 <= r_s1 + 38'(r_rd);
                        if (r_rage < {1'b0, r_long}) r_l0 <= r_l0 + 38'(r_rd);
                        if (r_rage >= 7'd1 && r_rage <= {1'b0, r_long})
                            r_l1 <= r_l1 + 38'(r_rd);
                    end
                    if (!r_rvalid && r_age > w_last) begin
                        r_cstep <= '0;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_cstep <= r_cstep + 2'd1;
                    case (r_cstep)
                        2'd0: r_a0 <= r_s0 * r_long;
                        2'd1: r_b0 <= r_l0 * r_short;
                        2'd2: r_a1 <= r_s1 * r_long;
                        default: begin
                            if (r_a0 >= r_b0 && r_a1 < (r_l1 * r_short)) begin
                                r_dstart <= 1'b1;
                                r_state  <= S_DIV;
                            end else if (r_b0 >= r_a0 && (r_l1 * r_short) < r_a1) begin
                                r_mdata <= {3'd0, 21'(r_openv - r_closedv),
                                            {2'b0, r_close} - dmac_pkg::PRICE_OFFSET,
                                            r_inst, dmac_pkg::ACT_SELL};
                                r_mvalid <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_mvalid <= 1'b1;
                                r_state  <= S_IDLE;
                            end
                        end
                    endcase
                end
                S_DIV: begin
                    r_dstart <= 1'b0;
                    if (w_div_done) begin
                        r_mdata <= {3'd0, 14'd0, w_qty,
                                    {2'b0, r_close} + dmac_pkg::PRICE_OFFSET,
                                    r_inst, dmac_pkg::ACT_BUY};
                        r_mvalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_IMPL(a_action_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
endmodule

/* hw/rtl/dmac_div.sv */
// Restoring divider for the buy quantity: floor(funds / (2*close)), capped at 100.
// Uses dmac_pkg for the cap; one quotient bit per cycle.
module dmac_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_funds,
    input  logic [31:0] i_close,
    output logic        o_done,
    output logic [6:0]  o_qty
);
    logic [39:0] r_num;
    logic [40:0] r_rem;
    logic [39:0] r_quo;
    logic [32:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [40:0] w_sh;
    logic [41:0] w_diff;

    assign w_sh   = {r_rem[39:0], r_num[39]};
    assign w_diff = {1'b0, w_sh} - {9'd0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 6'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd40;
                r_num  <= i_funds;
                r_rem  <= '0;
                r_quo  <= '0;
                r_den  <= {i_close, 1'b0};
            end else if (r_busy) begin
                r_num <= {r_num[38:0], 1'b0};
                if (!w_diff[41]) begin
                    r_rem <= w_diff[40:0];
                    r_quo <= {r_quo[38:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[38:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // zero divisor yields all-ones quotient; a zero close must give zero
    assign o_done = r_done;
    assign o_qty  = (r_den == '0) ? 7'd0 :
                    (r_quo > {33'd0, dmac_pkg::QTY_CAP}) ? dmac_pkg::QTY_CAP : r_quo[6:0];
endmodule

/* tb/sv/dual_moving_average_crossover_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for dual_moving_average_crossover: directed table, then random
// price walks under several register settings and flow-control patterns.
// Depends on dmac_pkg and the block's RTL.
module dual_moving_average_crossover_test;

    localparam int  WIN_SLOTS  = dmac_pkg::MAX_WINDOW_DEF;
    localparam int  NUM_INST   = dmac_pkg::NUM_INSTRUMENTS_DEF;
    localparam int  CYCLE_CAP  = 2000000;
    localparam int  DRAIN_WAIT = 250;

    typedef struct {
        logic [1:0]  act;
        logic [3:0]  inst;
        logic [33:0] price;
        logic [20:0] qty;
    } t_order;

    typedef struct {
        logic [3:0]  inst;
        logic [31:0] close;
        logic [39:0] funds;
        logic [19:0] openv;
        logic [19:0] closedv;
        bit          typed;   // expected result written in the row: no action
    } t_bar_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_index;
    logic [15:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;

    dual_moving_average_crossover u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor state
    logic [31:0] hist [NUM_INST][WIN_SLOTS];
    int unsigned fill [NUM_INST];
    int unsigned newest [NUM_INST];
    logic [15:0] enable_mask;
    int unsigned win_len, short_len, long_len;

    t_order pending_orders [$];
    int     errors;
    int     cycles;
    int     tx_idle_pct;
    int     rx_stall_pct;
    logic [31:0] walk_price [NUM_INST];

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [63:0] window_sum(int unsigned inst, int unsigned back,
                                               int unsigned len);
        logic [63:0] acc;
        int unsigned age;
        acc = 0;
        for (int unsigned k = 0; k < len; k++) begin
            age = (back + k) % WIN_SLOTS;
            acc += hist[inst][(newest[inst] + WIN_SLOTS - age) % WIN_SLOTS];
        end
        return acc;
    endfunction

    function automatic t_order crossover_decide(t_bar_row b);
        t_order o;
        int unsigned cap, slot;
        logic [63:0] a0, b0, a1, b1, q;
        o = '{dmac_pkg::ACT_NONE, 4'd0, 34'd0, 21'd0};
        if (!enable_mask[b.inst]) return o;
        slot = (newest[b.inst] + 1) % WIN_SLOTS;
        hist[b.inst][slot] = b.close;
        newest[b.inst] = slot;
        cap = (win_len < WIN_SLOTS) ? win_len : WIN_SLOTS;
        fill[b.inst] = (fill[b.inst] + 1 < cap) ? fill[b.inst] + 1 : cap;
        if (fill[b.inst] < win_len) return o;
        if (short_len == 0 || long_len == 0) return o;
        if (short_len >= win_len || long_len >= win_len) return o;
        // cross-multiplied so no division is needed for the averages
        a0 = window_sum(b.inst, 0, short_len) * long_len;
        b0 = window_sum(b.inst, 0, long_len) * short_len;
        a1 = window_sum(b.inst, 1, short_len) * long_len;
        b1 = window_sum(b.inst, 1, long_len) * short_len;
        if (a0 >= b0 && a1 < b1) begin
            q = 0;
            if (b.close != 0) begin
                q = {24'd0, b.funds} / ({32'd0, b.close} * 2);
                if (q > dmac_pkg::QTY_CAP) q = dmac_pkg::QTY_CAP;
            end
            o = '{dmac_pkg::ACT_BUY, b.inst, {2'b00, b.close} + dmac_pkg::PRICE_OFFSET,
                  q[20:0]};
        end else if (b0 >= a0 && b1 < a1) begin
            o = '{dmac_pkg::ACT_SELL, b.inst, {2'b00, b.close} - dmac_pkg::PRICE_OFFSET,
                  {1'b0, b.openv} - {1'b0, b.closedv}};
        end
        return o;
    endfunction

    // result side: check each transaction, then pick the next ready level
    always @(posedge i_clk) begin
        t_order got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[1:0], m_axis_tdata[5:2], m_axis_tdata[39:6],
                        m_axis_tdata[60:40]};
                if (pending_orders.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected order act=%0d inst=%0d price=%h qty=%h",
                             $time, got.act, got.inst, got.price, got.qty);
                end else begin
                    want = pending_orders.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: expected act=%0d inst=%0d price=%h qty=%h",
                                 $time, want.act, want.inst, want.price, want.qty);
                        $display("%0t: actual   act=%0d inst=%0d price=%h qty=%h",
                                 $time, got.act, got.inst, got.price, got.qty);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic write_settings(logic [15:0] en, int unsigned w, int unsigned s,
                                  int unsigned l);
        logic [15:0] vals [4];
        logic [1:0]  idx [4];
        vals = '{en, 16'(w), 16'(s), 16'(l)};
        idx  = '{dmac_pkg::REG_ENABLE, dmac_pkg::REG_WINDOW, dmac_pkg::REG_SHORT,
                 dmac_pkg::REG_LONG};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        enable_mask = en;
        win_len     = w & 7'h7F;
        short_len   = s & 6'h3F;
        long_len    = l & 6'h3F;
    endtask

    task automatic wait_drained();
        while (pending_orders.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // one input transaction; tvalid stays high across back-to-back items
    task automatic send_bar(t_bar_row b);
        t_order o;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, b.closedv, b.openv, b.funds, b.close, b.inst};
        do @(posedge i_clk); while (!s_axis_tready);
        o = crossover_decide(b);
        if (b.typed) o = '{dmac_pkg::ACT_NONE, 4'd0, 34'd0, 21'd0};
        pending_orders.insert(pending_orders.size(), o);
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_bar_row random_bar(int unsigned n_inst);
        t_bar_row b;
        int step;
        b.inst = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(n_inst - 1));
        if ($urandom_range(19) == 0) begin
            b.close = $urandom;
        end else begin
            step = int'($urandom_range(4000)) - 2000;
            b.close = walk_price[b.inst] + step;
            if (b.close < 32'd10000 || b.close > 32'hF000_0000) b.close = 32'd1000000;
        end
        walk_price[b.inst] = b.close;
        if ($urandom_range(3) == 0)
            b.funds = {8'($urandom), 32'($urandom)};
        else
            b.funds = 40'({8'd0, b.close} * 2 * $urandom_range(150));
        b.openv   = 20'($urandom);
        b.closedv = ($urandom_range(1) == 0) ? 20'($urandom) : 20'($urandom_range(1000));
        b.typed   = 1'b0;
        return b;
    endfunction

    t_bar_row directed [] = '{
        '{4'd3,  32'd1000,      40'd100000,        20'd5,       20'd1,       1'b1},
        '{4'd3,  32'd1000,      40'd100000,        20'd5,       20'd1,       1'b1},
        '{4'd15, 32'hFFFFFFFF,  40'hFF_FFFF_FFFF,  20'hFFFFF,   20'd0,       1'b1},
        '{4'd0,  32'd1,         40'd0,             20'd0,       20'hFFFFF,   1'b1},
        '{4'd3,  32'd1000,      40'd100000,        20'd5,       20'd1,       1'b0},
        '{4'd3,  32'd2000,      40'd100000,        20'd5,       20'd1,       1'b0},
        '{4'd3,  32'd500,       40'd100000,        20'd9,       20'd4,       1'b0},
        '{4'd3,  32'd0,         40'd12345,         20'd0,       20'd0,       1'b0},
        '{4'd3,  32'd0,         40'hFF_FFFF_FFFF,  20'd0,       20'd0,       1'b0},
        '{4'd3,  32'hFFFFFFFF,  40'hFF_FFFF_FFFF,  20'd0,       20'd0,       1'b0},
        '{4'd3,  32'd100,       40'd0,             20'd0,       20'hFFFFF,   1'b0},
        '{4'd3,  32'hFFFFFFFF,  40'hFF_FFFF_FFFF,  20'hFFFFF,   20'd0,       1'b0},
        '{4'd3,  32'd300,       40'd6000,          20'hFFFFF,   20'd0,       1'b0},
        '{4'd3,  32'd400,       40'd6000,          20'd7,       20'd7,       1'b0},
        '{4'd3,  32'd200,       40'd6000,          20'd7,       20'd8,       1'b0},
        '{4'd3,  32'd900,       40'd1799,          20'd7,       20'd8,       1'b0}
    };

    // settings per random phase: enable, window, short, long, items, instruments, idling
    int phase_cfg [10][7] = '{
        '{'hFFFF, 21,  5, 20, 140,  2, 0},
        '{'hFFFF,  4,  1,  3, 150,  4, 1},
        '{'hFFFF, 64, 63,  1, 150,  1, 2},
        '{'h5A5A,  6,  2,  5, 150, 16, 3},
        '{'hFFFF,  2,  1,  1,  50,  2, 0},
        '{'hFFFF,100,  5, 20,  40,  2, 1},
        '{'hFFFF,  5,  0,  3,  40,  2, 2},
        '{'hFFFF,  5,  3,  5,  40,  2, 3},
        '{'h0000,  8,  3,  7,  30,  4, 0},
        '{'hFFFF,  8,  3,  7, 150,  3, 0}
    };

    initial begin
        int idle_tx [4] = '{0, 88, 0, 16};
        int idle_rx [4] = '{0, 0, 88, 16};
        errors = 0;
        cycles = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = dmac_pkg::REG_ENABLE;
        i_cfg_data = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        for (int i = 0; i < NUM_INST; i++) begin
            fill[i] = 0;
            newest[i] = 0;
            walk_price[i] = 32'd1000000;
            for (int j = 0; j < WIN_SLOTS; j++) hist[i][j] = 32'd0;
        end
        enable_mask = 16'hFFFF;
        win_len = 21;
        short_len = 5;
        long_len = 20;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // instrument 15 off; tiny window so crosses come quickly
        write_settings(16'h7FFF, 3, 1, 2);
        foreach (directed[r]) send_bar(directed[r]);
        s_axis_tvalid <= 1'b0;

        for (int p = 0; p < 10; p++) begin
            wait_drained();
            write_settings(16'(phase_cfg[p][0]), phase_cfg[p][1], phase_cfg[p][2],
                           phase_cfg[p][3]);
            tx_idle_pct  = idle_tx[phase_cfg[p][6]];
            rx_stall_pct = idle_rx[phase_cfg[p][6]];
            for (int n = 0; n < phase_cfg[p][4]; n++)
                send_bar(random_bar(phase_cfg[p][5]));
            s_axis_tvalid <= 1'b0;
        end

        rx_stall_pct = 0;
        wait_drained();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
